FILE: design/c3v_pkg.sv
// c3v_pkg: shared constants, types and register codes for the 3x3 convolution stream
// no dependencies; imported by every module of the block
`default_nettype none

package c3v_pkg;

  // image geometry
  localparam int MAX_WIDTH = 4096;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int LW_W      = 13;
  localparam int CMP_W     = (COL_W + 1 > LW_W) ? COL_W + 1 : LW_W;
  localparam int ROW_W     = 12;
  localparam int ROW_LIMIT = 4095;
  localparam int POS_W     = 12;

  // payload widths
  localparam int PIX_W  = 16;
  localparam int PROD_W = 2 * PIX_W;
  localparam int ROWS_W = PROD_W + 2;
  localparam int SUM_W  = 35;
  localparam int COEF_W = 3 * PIX_W;

  // queue depths
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam int ODEPTH = 8;
  localparam int OPTR_W = $clog2(ODEPTH);
  localparam int OCNT_W = $clog2(ODEPTH + 1);

  // configuration registers
  localparam int CFG_IDX_W = 4;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_WIDTH    = 4'd0,
    REG_COEFFS_TOP    = 4'd1,
    REG_COEFFS_MIDDLE = 4'd2,
    REG_COEFFS_BOTTOM = 4'd3
  } cfg_reg_e;

  localparam logic [LW_W-1:0]   LINE_WIDTH_RESET = LW_W'(4000);
  localparam logic [COEF_W-1:0] COEFFS_RESET     = 48'h0001_0001_0001;

  // window and kernel: [row][col], row 0 oldest line, col 0 oldest column
  typedef logic signed [PIX_W-1:0] pix_t;
  typedef pix_t [2:0][2:0] win_t;

  // one window waiting for the multiply-accumulate
  typedef struct packed {
    win_t             win;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } job_t;

  // one finished result
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [POS_W-1:0]        row;
    logic [POS_W-1:0]        col;
  } res_t;

  // queue status seen by the intake full logic and the back end
  typedef struct packed {
    logic              empty;
    logic [QCNT_W-1:0] count;
  } qstat_t;

endpackage

`default_nettype wire

FILE: design/c3v_front.sv
// c3v_front: pixel intake, position counters, two line stores and the 3x3 window
// depends on c3v_pkg; feeds windows into c3v_queue
`default_nettype none

module c3v_front (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       accept,
  input  wire c3v_pkg::pix_t              pixel,
  input  wire logic                       frame_start,
  input  wire logic [c3v_pkg::LW_W-1:0]   line_width,
  output logic                            q_push,
  output c3v_pkg::job_t                   q_data,
  output logic                            busy
);
  import c3v_pkg::*;

  // position counters
  logic [COL_W-1:0] col_count;
  logic [ROW_W-1:0] row_count;

  // stage 1: pixel whose line-store read is in flight
  logic             s1_valid;
  logic             s1_prod;
  pix_t             s1_px;
  logic [COL_W-1:0] s1_col;
  logic [ROW_W-1:0] s1_row;

  // line stores and their registered read data
  pix_t older_mem [MAX_WIDTH];
  pix_t newer_mem [MAX_WIDTH];
  pix_t rd_older;
  pix_t rd_newer;

  win_t win;
  win_t win_next;

  logic [COL_W-1:0] col_cur;
  logic [ROW_W-1:0] row_cur;
  logic [CMP_W-1:0] eff_width;
  logic [CMP_W-1:0] col_inc;
  logic             wrap;
  logic             same_col;

  // position of the incoming pixel and wrap decision
  always_comb begin
    col_cur = frame_start ? '0 : col_count;
    row_cur = frame_start ? '0 : row_count;
    if (CMP_W'(line_width) < CMP_W'(3)) begin
      eff_width = CMP_W'(3);
    end else if (CMP_W'(line_width) > CMP_W'(MAX_WIDTH)) begin
      eff_width = CMP_W'(MAX_WIDTH);
    end else begin
      eff_width = CMP_W'(line_width);
    end
    col_inc  = CMP_W'(col_cur) + CMP_W'(1);
    wrap     = col_inc >= eff_width;
    same_col = s1_valid && (s1_col == col_cur);
  end

  // counters and stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      s1_valid  <= 1'b0;
      s1_prod   <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        s1_prod <= (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(2));
        if (wrap) begin
          col_count <= '0;
          row_count <= (row_cur < ROW_W'(ROW_LIMIT)) ? row_cur + ROW_W'(1) : row_cur;
        end else begin
          col_count <= col_inc[COL_W-1:0];
          row_count <= row_cur;
        end
      end
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px  <= pixel;
      s1_col <= col_cur;
      s1_row <= row_cur;
    end
  end

  // line stores: read at intake, write in the next cycle, forward on same column
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      older_mem[s1_col] <= rd_newer;
      newer_mem[s1_col] <= s1_px;
    end
    if (accept) begin
      rd_older <= same_col ? rd_newer : older_mem[col_cur];
      rd_newer <= same_col ? s1_px : newer_mem[col_cur];
    end
  end

  // window shift with the new right column
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_next[r][0] = win[r][1];
      win_next[r][1] = win[r][2];
    end
    win_next[0][2] = rd_older;
    win_next[1][2] = rd_newer;
    win_next[2][2] = s1_px;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (s1_valid) begin
      win <= win_next;
    end
  end

  // hand full windows to the queue
  assign q_push     = s1_valid && s1_prod;
  assign q_data.win = win_next;
  assign q_data.row = POS_W'(s1_row - ROW_W'(2));
  assign q_data.col = POS_W'(s1_col - COL_W'(2));
  assign busy       = s1_valid;

  // a frame start always lands at the top left corner
  a_frame_origin: assert property (@(posedge clk) disable iff (rst)
    accept && frame_start |=> s1_col == '0 && s1_row == '0)
    else $error("frame start did not clear position");

  // a window is pushed only at a position with a full neighborhood
  a_push_pos: assert property (@(posedge clk) disable iff (rst)
    q_push |-> s1_col >= COL_W'(2) && s1_row >= ROW_W'(2))
    else $error("window pushed too early");

endmodule

`default_nettype wire

FILE: design/c3v_queue.sv
// c3v_queue: short window queue between the front end and the multiply-accumulate
// depends on c3v_pkg
`default_nettype none

module c3v_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire c3v_pkg::job_t  wr_data,
  input  wire logic           pop,
  output c3v_pkg::job_t       rd_data,
  output c3v_pkg::qstat_t     stat
);
  import c3v_pkg::*;

  job_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  assign rd_data    = slots[rd_ptr];
  assign stat.count = count;
  assign stat.empty = (count == '0);

  // credit accounting must keep the queue from overflowing
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> count < QCNT_W'(QDEPTH))
    else $error("window queue overflow");

endmodule

`default_nettype wire

FILE: design/c3v_back.sv
// c3v_back: nine-tap multiply, row sums, final sum and the result queue
// depends on c3v_pkg; reads windows from c3v_queue
`default_nettype none

module c3v_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire c3v_pkg::qstat_t qstat,
  input  wire c3v_pkg::job_t   job,
  output logic                 q_pop,
  input  wire c3v_pkg::win_t   coeffs,
  input  wire logic            out_pop,
  output logic                 out_empty,
  output c3v_pkg::res_t        out_data
);
  import c3v_pkg::*;

  // stage a: products
  logic                     a_valid;
  logic signed [PROD_W-1:0] prod [3][3];
  logic [POS_W-1:0]         a_row;
  logic [POS_W-1:0]         a_col;

  // stage b: row sums
  logic                     b_valid;
  logic signed [ROWS_W-1:0] rsum [3];
  logic [POS_W-1:0]         b_row;
  logic [POS_W-1:0]         b_col;

  // result queue
  res_t              slots [ODEPTH];
  logic [OPTR_W-1:0] wr_ptr;
  logic [OPTR_W-1:0] rd_ptr;
  logic [OCNT_W-1:0] o_count;
  logic [OCNT_W-1:0] in_flight;
  logic              o_pop;
  res_t              res;

  // take a window only when the result queue has room for everything in flight
  always_comb begin
    in_flight = o_count + OCNT_W'(a_valid) + OCNT_W'(b_valid);
    q_pop     = !qstat.empty && (in_flight < OCNT_W'(ODEPTH));
    o_pop     = out_pop && !out_empty;
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      a_valid <= q_pop;
      b_valid <= a_valid;
    end
  end

  // nine products
  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          prod[r][k] <= $signed(job.win[r][k]) * $signed(coeffs[r][k]);
        end
      end
      a_row <= job.row;
      a_col <= job.col;
    end
  end

  // per-row sums
  always_ff @(posedge clk) begin
    if (a_valid) begin
      for (int r = 0; r < 3; r++) begin
        rsum[r] <= ROWS_W'(prod[r][0]) + ROWS_W'(prod[r][1]) + ROWS_W'(prod[r][2]);
      end
      b_row <= a_row;
      b_col <= a_col;
    end
  end

  // final sum
  always_comb begin
    res.sum = SUM_W'(rsum[0]) + SUM_W'(rsum[1]) + SUM_W'(rsum[2]);
    res.row = b_row;
    res.col = b_col;
  end

  // result queue pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      o_count <= '0;
    end else begin
      if (b_valid) begin
        wr_ptr <= wr_ptr + OPTR_W'(1);
      end
      if (o_pop) begin
        rd_ptr <= rd_ptr + OPTR_W'(1);
      end
      o_count <= o_count + OCNT_W'(b_valid) - OCNT_W'(o_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid) begin
      slots[wr_ptr] <= res;
    end
  end

  assign out_empty = (o_count == '0);
  assign out_data  = slots[rd_ptr];

  // a finished sum always finds room
  a_res_room: assert property (@(posedge clk) disable iff (rst)
    b_valid && !o_pop |-> o_count < OCNT_W'(ODEPTH))
    else $error("result queue overflow");

  // credit bound holds across the pipeline
  a_credit: assert property (@(posedge clk) disable iff (rst)
    in_flight <= OCNT_W'(ODEPTH))
    else $error("too many results in flight");

endmodule

`default_nettype wire

FILE: design/conv3x3_valid_stream.sv
// conv3x3_valid_stream: streaming valid-mode 3x3 convolution, top level and config registers
// depends on c3v_pkg, c3v_front, c3v_queue, c3v_back
//
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+------------------------------
//  pixels   | in        | push / full       | pixel, frame_start
//  results  | out       | empty / pop       | window_sum, out_row, out_col
//  config   | in        | cfg_valid / ready | cfg_index, cfg_data
//
// one pixel per cycle sustained while full stays low; the line stores are single write, single read
// and the nine-tap sum runs as a pipeline of products, row sums and final sum after a 4-deep window queue
// a result passes the front stage, window queue, product and row-sum stages and result queue
// reset clears counters, window and queues; line stores need no clearing pass
// full rises when the window queue, counting a window still in the front stage, has no
// room; pop stalls back through the 8-deep result queue and the window queue to full
`default_nettype none

module conv3x3_valid_stream (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic signed [15:0]             pixel,
  input  wire logic                           frame_start,
  output logic                                empty,
  input  wire logic                           pop,
  output logic signed [34:0]                  window_sum,
  output logic [11:0]                         out_row,
  output logic [11:0]                         out_col,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [c3v_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [c3v_pkg::COEF_W-1:0]     cfg_data
);
  import c3v_pkg::*;

  logic [LW_W-1:0]   line_width;
  logic [COEF_W-1:0] coeffs_top_row;
  logic [COEF_W-1:0] coeffs_middle_row;
  logic [COEF_W-1:0] coeffs_bottom_row;
  win_t              coeffs;

  logic   accept;
  logic   q_push;
  logic   q_pop;
  logic   front_busy;
  job_t   q_wr;
  job_t   q_rd;
  qstat_t qstat;
  res_t   res;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width        <= LINE_WIDTH_RESET;
      coeffs_top_row    <= COEFFS_RESET;
      coeffs_middle_row <= COEFFS_RESET;
      coeffs_bottom_row <= COEFFS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LINE_WIDTH:    line_width        <= cfg_data[LW_W-1:0];
        REG_COEFFS_TOP:    coeffs_top_row    <= cfg_data;
        REG_COEFFS_MIDDLE: coeffs_middle_row <= cfg_data;
        REG_COEFFS_BOTTOM: coeffs_bottom_row <= cfg_data;
        default: ;
      endcase
    end
  end

  assign coeffs = {coeffs_bottom_row, coeffs_middle_row, coeffs_top_row};

  // reserve a queue slot for a window still in the front pipeline
  assign full   = (QCNT_W'(qstat.count) + QCNT_W'(front_busy)) >= QCNT_W'(QDEPTH);
  assign accept = push && !full;

  c3v_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .pixel       (pixel),
    .frame_start (frame_start),
    .line_width  (line_width),
    .q_push      (q_push),
    .q_data      (q_wr),
    .busy        (front_busy)
  );

  c3v_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr),
    .pop     (q_pop),
    .rd_data (q_rd),
    .stat    (qstat)
  );

  c3v_back u_back (
    .clk       (clk),
    .rst       (rst),
    .qstat     (qstat),
    .job       (q_rd),
    .q_pop     (q_pop),
    .coeffs    (coeffs),
    .out_pop   (pop),
    .out_empty (empty),
    .out_data  (res)
  );

  assign window_sum = res.sum;
  assign out_row    = res.row;
  assign out_col    = res.col;

endmodule

`default_nettype wire
